// ===== rtl/core/trial_division_prime_filter_unit_defines.svh =====
// Assertion macros shared by the prime filter checker.
`ifndef TRIAL_DIVISION_PRIME_FILTER_UNIT_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TDPF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdpf assertion failed");

// Next-cycle implication, disabled while in reset.
`define TDPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdpf assertion failed");

`endif

// ===== rtl/core/tdpf_pkg.sv =====
// Shared types and constants for the trial division prime filter.
`timescale 1ns / 1ps

package tdpf_pkg;

  localparam int CAND_W  = 16;
  localparam int TALLY_W = 13;
  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic set_verdict;
    logic verdict;
    logic init_d;
    logic div_start;
    logic div_step;
    logic adv_d;
    logic publish;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic n_lt2;
    logic n_two;
    logic n_even;
    logic sq_gt_n;
    logic rem_zero;
    logic bit_zero;
  } sts_t;

endpackage

// ===== rtl/core/trial_division_prime_filter_unit.sv =====
// Top level of the trial division prime filter.
// Screening: 0, 1, 2 and even numbers get their verdict in the check state; odd n are then
// divided by the odd divisors 3, 5, ... until one divides n or d*d > n ends it.
// One item at a time: input stalls until the result is published; each trial runs a
// bit-serial remainder loop over the NW = data bits of n.
// Reset clears the controller, the result valid and the prime count.
`timescale 1ns / 1ps

module trial_division_prime_filter_unit #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tdpf_pkg::CAND_W-1:0]   candidate,
  input  logic                          start_of_range,
  input  logic                          end_of_range,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          is_prime,
  output logic [tdpf_pkg::TALLY_W-1:0]  primes_so_far,
  output logic                          range_done
);
  import tdpf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the work
  tdpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold operands, divide, count
  tdpf_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .candidate      (candidate),
    .start_of_range (start_of_range),
    .end_of_range   (end_of_range),
    .cmd            (cmd),
    .sts            (sts),
    .is_prime       (is_prime),
    .primes_so_far  (primes_so_far),
    .range_done     (range_done)
  );

endmodule

// ===== rtl/core/tdpf_ctrl.sv =====
// Controller state machine for the trial division prime filter.
`timescale 1ns / 1ps

module tdpf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  tdpf_pkg::sts_t sts,
  output tdpf_pkg::cmd_t cmd
);
  import tdpf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_TEST  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Sequence one item: screen, then divide by odd divisors until one divides n or d*d > n
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.n_lt2) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b0;
          state_next      = S_DONE;
        end else if (sts.n_two) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b1;
          state_next      = S_DONE;
        end else if (sts.n_even) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b0;
          state_next      = S_DONE;
        end else begin
          cmd.init_d = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.sq_gt_n) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b1;
          state_next      = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.bit_zero) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.rem_zero) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b0;
          state_next      = S_DONE;
        end else begin
          cmd.adv_d  = 1'b1;
          state_next = S_TEST;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state; hold the result valid until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/tdpf_datapath.sv =====
// Datapath of the prime filter: divisor stepping, bit-serial remainder, tally.
`timescale 1ns / 1ps

module tdpf_datapath #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [tdpf_pkg::CAND_W-1:0]    candidate,
  input  logic                           start_of_range,
  input  logic                           end_of_range,
  input  tdpf_pkg::cmd_t                 cmd,
  output tdpf_pkg::sts_t                 sts,
  output logic                           is_prime,
  output logic [tdpf_pkg::TALLY_W-1:0]   primes_so_far,
  output logic                           range_done
);
  import tdpf_pkg::*;

  // Candidate bits in use, divisor and square widths with headroom
  localparam int NW  = (VALUE_WIDTH < CAND_W) ? VALUE_WIDTH : CAND_W;
  localparam int DW  = (NW + 1) / 2 + 2;
  localparam int SQW = 2 * DW;
  localparam int BW  = $clog2(NW);

  logic [NW-1:0]      n;
  logic               start_q;
  logic               last_q;
  logic [DW-1:0]      d;
  logic [SQW-1:0]     sq;
  logic [DW-1:0]      rem;
  logic [BW-1:0]      bitcnt;
  logic               verdict;
  logic [TALLY_W-1:0] tally;
  logic [TALLY_W-1:0] tally_base;
  logic [TALLY_W-1:0] tally_next;
  logic [DW:0]        rem_shift;
  logic [DW:0]        rem_diff;
  logic               res_prime;
  logic [TALLY_W-1:0] res_count;
  logic               res_last;

  // Restoring remainder step: shift in one candidate bit, subtract if it fits
  assign rem_shift = {rem, n[bitcnt]};
  assign rem_diff  = rem_shift - {1'b0, d};

  // Clear on start of range, count a prime unless saturated
  assign tally_base = start_q ? '0 : tally;
  assign tally_next = (verdict && (tally_base != TALLY_MAX)) ?
                      tally_base + TALLY_W'(1) : tally_base;

  assign sts.n_lt2    = (n[NW-1:1] == '0);
  assign sts.n_two    = (n == NW'(2));
  assign sts.n_even   = !n[0];
  assign sts.sq_gt_n  = (sq > SQW'(n));
  assign sts.rem_zero = (rem == '0);
  assign sts.bit_zero = (bitcnt == '0);

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n       <= candidate[NW-1:0];
      start_q <= start_of_range;
      last_q  <= end_of_range;
    end
    if (cmd.set_verdict) begin
      verdict <= cmd.verdict;
    end
    if (cmd.init_d) begin
      d  <= DW'(3);
      sq <= SQW'(9);
    end else if (cmd.adv_d) begin
      d  <= d + DW'(2);
      sq <= sq + SQW'({d, 2'b00}) + SQW'(4);
    end
    if (cmd.div_start) begin
      rem    <= '0;
      bitcnt <= BW'(NW - 1);
    end else if (cmd.div_step) begin
      rem    <= rem_diff[DW] ? rem_shift[DW-1:0] : rem_diff[DW-1:0];
      bitcnt <= bitcnt - BW'(1);
    end
    if (cmd.publish) begin
      res_prime <= verdict;
      res_count <= tally_next;
      res_last  <= last_q;
    end
  end

  // Running prime count
  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (cmd.publish) begin
      tally <= tally_next;
    end
  end

  assign is_prime      = res_prime;
  assign primes_so_far = res_count;
  assign range_done    = res_last;

endmodule

// ===== rtl/core/tdpf_checker.sv =====
// Port-level checker for the prime filter, bound to the top level.
`timescale 1ns / 1ps
`include "trial_division_prime_filter_unit_defines.svh"

module tdpf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [15:0] candidate,
  input logic        start_of_range,
  input logic        end_of_range,
  input logic        out_valid,
  input logic        out_stall,
  input logic        is_prime,
  input logic [12:0] primes_so_far,
  input logic        range_done
);

  logic out_hold;

  assign out_hold = out_valid && out_stall;

  // A prime result always carries a nonzero count
  `TDPF_ASSERT_NOW(a_prime_counted, clk, rst, out_valid && is_prime, primes_so_far != 13'd0)
  // Work starts on the accepted item, so input is stalled right after
  `TDPF_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // No result is pending right after reset
  `TDPF_ASSERT_NOW(a_reset_clears_valid, clk, rst, $past(rst), !out_valid)
  // A stalled result holds
  `TDPF_ASSERT_NEXT(a_out_hold, clk, rst, out_hold, out_valid && $stable(is_prime) && $stable(primes_so_far) && $stable(range_done))

endmodule

bind trial_division_prime_filter_unit tdpf_checker u_tdpf_checker (.*);

// ===== sim/trial_division_prime_filter_unit_tb.sv =====
// Self-checking testbench for the trial division prime filter unit.
`timescale 1ns / 1ps

module trial_division_prime_filter_unit_tb;
  import tdpf_pkg::*;

  localparam int VW         = 16;
  localparam int LIMIT      = 2_000_000;
  localparam int DRAIN      = 2400;
  localparam int RAND_ITEMS = 80;
  localparam int N_PROBES   = 23;

  typedef struct packed {
    logic               prime;
    logic [TALLY_W-1:0] count;
    logic               done;
  } verdict_t;

  typedef struct {
    logic [CAND_W-1:0] cand;
    bit                s;
    bit                e;
    bit                typed;
    bit                p;
    int                cnt;
  } probe_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CAND_W-1:0]  candidate = '0;
  logic               start_of_range = 1'b0;
  logic               end_of_range = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               is_prime;
  logic [TALLY_W-1:0] primes_so_far;
  logic               range_done;

  // Predictor state and scoreboard
  logic [TALLY_W-1:0] tally = '0;
  verdict_t           pending_verdicts[$];
  verdict_t           oldest;
  bit                 quiet = 1'b0;
  int                 cycle_count = 0;
  int                 mismatches = 0;
  int                 items_sent = 0;
  int                 results_checked = 0;
  int                 prime_hits = 0;

  // Directed items: typed verdicts where obvious, predictor elsewhere
  probe_t probes [0:N_PROBES-1] = '{
    '{16'd0,     1'b0, 1'b0, 1'b1, 1'b0, 0},
    '{16'd1,     1'b0, 1'b0, 1'b1, 1'b0, 0},
    '{16'd2,     1'b0, 1'b0, 1'b1, 1'b1, 1},
    '{16'd3,     1'b0, 1'b0, 1'b1, 1'b1, 2},
    '{16'd4,     1'b0, 1'b0, 1'b1, 1'b0, 2},
    '{16'd5,     1'b0, 1'b0, 1'b1, 1'b1, 3},
    '{16'd7,     1'b0, 1'b0, 1'b1, 1'b1, 4},
    '{16'd9,     1'b0, 1'b0, 1'b1, 1'b0, 4},
    '{16'd25,    1'b0, 1'b0, 1'b1, 1'b0, 4},
    '{16'd49,    1'b0, 1'b0, 1'b0, 1'b0, 0},
    '{16'd11,    1'b0, 1'b1, 1'b1, 1'b1, 5},
    '{16'd13,    1'b0, 1'b0, 1'b1, 1'b1, 6},
    '{16'd65535, 1'b1, 1'b0, 1'b1, 1'b0, 0},
    '{16'd65521, 1'b0, 1'b0, 1'b0, 1'b0, 0},
    '{16'd32768, 1'b0, 1'b0, 1'b0, 1'b0, 0},
    '{16'd2,     1'b1, 1'b1, 1'b1, 1'b1, 1},
    '{16'd15,    1'b0, 1'b0, 1'b1, 1'b0, 1},
    '{16'd121,   1'b0, 1'b0, 1'b0, 1'b0, 0},
    '{16'd32749, 1'b0, 1'b0, 1'b0, 1'b0, 0},
    '{16'hAAAA,  1'b0, 1'b0, 1'b0, 1'b0, 0},
    '{16'h5555,  1'b0, 1'b0, 1'b0, 1'b0, 0},
    '{16'd65533, 1'b0, 1'b1, 1'b0, 1'b0, 0},
    '{16'd1,     1'b1, 1'b1, 1'b1, 1'b0, 0}
  };

  trial_division_prime_filter_unit #(
    .VALUE_WIDTH(VW)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .candidate     (candidate),
    .start_of_range(start_of_range),
    .end_of_range  (end_of_range),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_prime      (is_prime),
    .primes_so_far (primes_so_far),
    .range_done    (range_done)
  );

  always #5 clk = ~clk;

  // Trial division over odd divisors up to the square root
  function automatic logic judge_prime(input int unsigned n);
    int unsigned d;
    if (n < 2) return 1'b0;
    if (n == 2 || n == 3 || n == 5 || n == 7) return 1'b1;
    if (n % 2 == 0 || n % 5 == 0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the prime count for one item and return its verdict
  function automatic verdict_t count_prime(input logic [CAND_W-1:0] c, input bit s,
                                           input bit e);
    verdict_t    v;
    int unsigned n;
    n = 32'(c & ((64'd1 << VW) - 1));
    if (s) tally = '0;
    v.prime = judge_prime(n);
    if (v.prime && tally != TALLY_MAX) tally = tally + 1'b1;
    v.count = tally;
    v.done  = e;
    return v;
  endfunction

  task automatic report(input string what, input int got, input int wanted);
    mismatches++;
    if (mismatches <= 30)
      $display("MISMATCH %s: got %0d, wanted %0d (result %0d)", what, got, wanted,
               results_checked);
  endtask

  // Offer one item, hold it until accepted, then log its verdict
  task automatic offer(input logic [CAND_W-1:0] c, input bit s, input bit e,
                       input bit typed, input verdict_t typed_v);
    verdict_t v;
    while (!quiet && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    candidate      <= c;
    start_of_range <= s;
    end_of_range   <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    v = count_prime(c, s, e);
    pending_verdicts.push_back(typed ? typed_v : v);
    items_sent++;
  endtask

  // Small numbers in 35 of 100 picks, numbers near the top in 15, the rest anywhere
  function automatic logic [CAND_W-1:0] pick_candidate();
    int r;
    r = $urandom_range(99);
    if (r < 35) return CAND_W'($urandom_range(300));
    if (r < 50) return CAND_W'(16'hFFFF - $urandom_range(300));
    return CAND_W'($urandom_range(16'hFFFF));
  endfunction

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 24);
  end

  // Compare each accepted result with the oldest verdict
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report("result with nothing pending", primes_so_far, -1);
      end else begin
        oldest = pending_verdicts.pop_front();
        if (is_prime !== oldest.prime) report("is_prime", is_prime, oldest.prime);
        if (primes_so_far !== oldest.count)
          report("primes_so_far", primes_so_far, oldest.count);
        if (range_done !== oldest.done) report("range_done", range_done, oldest.done);
        if (oldest.prime) prime_hits++;
      end
      results_checked++;
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_verdicts.size());
      $display("trial_division_prime_filter_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    verdict_t tv;
    int       rand_items;
    int       span;
    bit       broken;
    bit       s;
    bit       e;
    rand_items = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int i = 0; i < N_PROBES; i++) begin
      tv.prime = probes[i].p;
      tv.count = probes[i].cnt[TALLY_W-1:0];
      tv.done  = probes[i].e;
      offer(probes[i].cand, probes[i].s, probes[i].e, probes[i].typed, tv);
    end

    // Random ranges, mostly well formed, with a quiet stretch in the middle
    while (rand_items < RAND_ITEMS) begin
      span   = $urandom_range(1, 12);
      broken = ($urandom_range(99) < 20);
      for (int j = 0; j < span; j++) begin
        s     = broken ? bit'($urandom_range(1)) : (j == 0);
        e     = broken ? bit'($urandom_range(1)) : (j == span - 1);
        quiet = (rand_items >= 35 && rand_items < 65);
        offer(pick_candidate(), s, e, 1'b0, '0);
        rand_items++;
      end
    end
    quiet    = 1'b0;
    in_valid <= 1'b0;

    // Drain, then watch for stray results
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("run covered %0d items: %0d directed, %0d random in ranges with stalls",
             items_sent, N_PROBES, rand_items);
    $display("%0d results checked, %0d primes, %0d mismatches",
             results_checked, prime_hits, mismatches);
    if (mismatches == 0) begin
      $display("trial_division_prime_filter_unit_tb: clean");
    end else begin
      $display("trial_division_prime_filter_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tdpf_pkg.sv
rtl/core/tdpf_ctrl.sv
rtl/core/tdpf_datapath.sv
rtl/core/trial_division_prime_filter_unit.sv
rtl/core/tdpf_checker.sv
sim/trial_division_prime_filter_unit_tb.sv
